### design/bslc_pkg.sv
package bslc_pkg;

  localparam int BUTTONS = 3;
  localparam int IDX_W = 2;
  localparam int CD_W = 10;
  localparam int HELD_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG = 2'd3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic KIND_SHORT = 1'b0;
  localparam logic KIND_LONG = 1'b1;

  typedef struct packed {
    logic [BUTTONS-1:0] hit;
    logic [BUTTONS-1:0] kind;
  } tick_rec_t;

endpackage

### design/bslc_front.sv
module bslc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [bslc_pkg::BUTTONS-1:0]      raw_levels,
  input  logic                              cfg_we,
  input  logic [bslc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bslc_pkg::CFG_W-1:0]        cfg_data,
  output logic                              rec_push,
  output bslc_pkg::tick_rec_t               rec
);

  localparam int B = bslc_pkg::BUTTONS;
  localparam int CW = bslc_pkg::CD_W;
  localparam int HW = bslc_pkg::HELD_W;

  logic [7:0]    debounce_ticks;
  logic [CW-1:0] check_period_ticks;
  logic [HW-1:0] short_limit_ticks;
  logic [HW-1:0] long_limit_ticks;

  logic [B-1:0]  prev_raw, prev_raw_next;
  logic [CW-1:0] countdown [B];
  logic [CW-1:0] countdown_next [B];
  logic [B-1:0]  armed, armed_next;
  logic [B-1:0]  pressed, pressed_next;
  logic [HW-1:0] held [B];
  logic [HW-1:0] held_next [B];
  logic [B-1:0]  long_rep, long_rep_next;
  logic [B-1:0]  hit, kind;

  logic [CW-1:0] deb_load, per_load;

  assign deb_load = (debounce_ticks == 8'd0) ? CW'(1) : CW'(debounce_ticks);
  assign per_load = (check_period_ticks == '0) ? CW'(1) : check_period_ticks;

  always_comb begin
    logic [CW-1:0] cd_dec;
    logic [HW-1:0] h;
    for (int i = 0; i < B; i++) begin
      prev_raw_next[i] = prev_raw[i];
      countdown_next[i] = countdown[i];
      armed_next[i] = armed[i];
      pressed_next[i] = pressed[i];
      long_rep_next[i] = long_rep[i];
      hit[i] = 1'b0;
      kind[i] = bslc_pkg::KIND_SHORT;
      h = (pressed[i] && held[i] != '1) ? held[i] + HW'(1) : held[i];
      held_next[i] = h;
      cd_dec = (countdown[i] != '0) ? countdown[i] - CW'(1) : countdown[i];
      if (raw_levels[i] != prev_raw[i]) begin
        prev_raw_next[i] = raw_levels[i];
        countdown_next[i] = deb_load;
        armed_next[i] = 1'b1;
      end else if (armed[i]) begin
        countdown_next[i] = cd_dec;
        if (cd_dec == '0) begin
          if (raw_levels[i] != pressed[i]) begin
            if (raw_levels[i]) begin
              pressed_next[i] = 1'b1;
              held_next[i] = '0;
              long_rep_next[i] = 1'b0;
              countdown_next[i] = per_load;
              armed_next[i] = 1'b1;
            end else begin
              pressed_next[i] = 1'b0;
              armed_next[i] = 1'b0;
              if (!long_rep[i] && h < short_limit_ticks) begin
                hit[i] = 1'b1;
              end
            end
          end else if (pressed[i] && !long_rep[i]) begin
            if (h >= long_limit_ticks) begin
              long_rep_next[i] = 1'b1;
              hit[i] = 1'b1;
              kind[i] = bslc_pkg::KIND_LONG;
            end
            countdown_next[i] = per_load;
            armed_next[i] = 1'b1;
          end else begin
            armed_next[i] = 1'b0;
          end
        end
      end
    end
  end

  assign rec_push = accept && (hit != '0);
  assign rec.hit = hit;
  assign rec.kind = kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= 8'd20;
      check_period_ticks <= CW'(100);
      short_limit_ticks <= HW'(500);
      long_limit_ticks <= HW'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bslc_pkg::REG_DEBOUNCE: debounce_ticks <= cfg_data[7:0];
        bslc_pkg::REG_PERIOD:   check_period_ticks <= cfg_data[CW-1:0];
        bslc_pkg::REG_SHORT:    short_limit_ticks <= cfg_data[HW-1:0];
        bslc_pkg::REG_LONG:     long_limit_ticks <= cfg_data[HW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_raw <= '0;
      armed <= '0;
      pressed <= '0;
      long_rep <= '0;
      for (int i = 0; i < B; i++) begin
        countdown[i] <= '0;
        held[i] <= '0;
      end
    end else if (accept) begin
      prev_raw <= prev_raw_next;
      armed <= armed_next;
      pressed <= pressed_next;
      long_rep <= long_rep_next;
      for (int i = 0; i < B; i++) begin
        countdown[i] <= countdown_next[i];
        held[i] <= held_next[i];
      end
    end
  end

endmodule

### design/bslc_queue.sv
module bslc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  bslc_pkg::tick_rec_t wr_rec,
  input  logic                rd_en,
  output bslc_pkg::tick_rec_t rd_rec,
  output logic                full,
  output logic                not_empty
);

  localparam int AW = bslc_pkg::Q_AW;

  bslc_pkg::tick_rec_t mem [bslc_pkg::Q_DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          do_wr, do_rd;

  assign full = (count == (AW+1)'(bslc_pkg::Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && not_empty;
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + (AW+1)'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

### design/bslc_back.sv
module bslc_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_not_empty,
  input  bslc_pkg::tick_rec_t            q_rec,
  output logic                           q_pop,
  input  logic                           pop,
  output logic                           empty,
  output logic [bslc_pkg::IDX_W-1:0]     button_index,
  output logic                           click_kind,
  output logic                           last_of_tick
);

  localparam int B = bslc_pkg::BUTTONS;

  logic [B-1:0] cur_hit, cur_kind, rem;
  logic [bslc_pkg::IDX_W-1:0] sel;
  logic found, emit, out_valid;

  always_comb begin
    sel = '0;
    found = 1'b0;
    for (int i = 0; i < B; i++) begin
      if (cur_hit[i] && !found) begin
        sel = bslc_pkg::IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign rem = cur_hit & (cur_hit - B'(1));
  assign emit = found && (!out_valid || pop);
  assign q_pop = q_not_empty && (!found || (emit && rem == '0));
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_hit <= '0;
    end else if (q_pop) begin
      cur_hit <= q_rec.hit;
    end else if (emit) begin
      cur_hit <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_kind <= q_rec.kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      button_index <= sel;
      click_kind <= cur_kind[sel];
      last_of_tick <= (rem == '0);
    end
  end

endmodule

### design/button_short_long_click_detector.sv
// Each tick's clicks are worked out at once, as the tick is accepted.
// A tick may follow in every cycle while the four-entry click queue has room.
// The first click of a tick passes through the click queue, the back end's hit
// register and the result registers; further clicks of the same tick follow one per cycle while pop is held.
// Synchronous rst clears all button state and the click queue and restores the
// register defaults of 20, 100, 500 and 1000 ticks.
module button_short_long_click_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [bslc_pkg::BUTTONS-1:0]       raw_levels,
  output logic                               empty,
  input  logic                               pop,
  output logic [bslc_pkg::IDX_W-1:0]         button_index,
  output logic                               click_kind,
  output logic                               last_of_tick,
  input  logic                               cfg_we,
  input  logic [bslc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bslc_pkg::CFG_W-1:0]         cfg_data
);

  bslc_pkg::tick_rec_t wr_rec, rd_rec;
  logic rec_push, q_pop, q_not_empty, accept;

  assign accept = push && !full;

  bslc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .raw_levels (raw_levels),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rec_push   (rec_push),
    .rec        (wr_rec)
  );

  bslc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (rec_push),
    .wr_rec    (wr_rec),
    .rd_en     (q_pop),
    .rd_rec    (rd_rec),
    .full      (full),
    .not_empty (q_not_empty)
  );

  bslc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_rec        (rd_rec),
    .q_pop        (q_pop),
    .pop          (pop),
    .empty        (empty),
    .button_index (button_index),
    .click_kind   (click_kind),
    .last_of_tick (last_of_tick)
  );

endmodule
